>>> hdl/ise_pkg.sv
// Package: shared types, sizes and codes for the indexed stack engine.
package ise_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int LIMIT_W    = 5;
	localparam int PADDR_W    = 3;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_CHANGE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_OVERFLOW  = 2'd1,
		STS_UNDERFLOW = 2'd2
	} sts_t;

	typedef enum logic [0:0] {
		REG_STACK_LIMIT = 1'b0
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value;
		logic [4:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_data;
		logic [1:0]         status;
		logic [4:0]         count_now;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_ctl_t;

endpackage

>>> hdl/indexed_stack_engine.sv
// Top level: LIFO stack engine with push, pop, peek and change, plus APB limit register.
//
//  channel   handshake                    payload
//  --------  ---------------------------  -------------------------------------
//  request   start & !busy                req  (command, value, position)
//  response  done, one cycle, no stall    rsp  (read_data, status, count_now)
//  config    psel & penable & pwrite      paddr, pwdata, prdata, pready (=1)
//
// A request passes through accept, execute (one memory access and the
// count update) and respond. busy stays high from the accept edge until
// the cycle after done, so no new request is taken before the last one
// has responded.
// arst_n clears the controller, the entry count and the limit (to 16).
// The stack memory has no reset; only entries below the count ever reach read_data.
// The response receiver cannot stall: done is a one-cycle strobe.
module indexed_stack_engine
	import ise_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  req_t               req,
	output logic               done,
	output rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	dp_ctl_t            ctl;
	logic [LIMIT_W-1:0] stack_limit_q;
	logic               cfg_wr;
	logic               sel_limit;

	// Decode the register index from the word address; drop writes beyond it.
	assign sel_limit = (reg_idx_t'(paddr[PADDR_W-1:2]) == REG_STACK_LIMIT);
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;

	// Hold the push limit; only the low five bits of the write data count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_limit_q <= LIMIT_W'(16);
		end else if (cfg_wr && sel_limit) begin
			stack_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign prdata = sel_limit ? 32'(stack_limit_q) : 32'd0;

	// Advance one request through load, execute, respond.
	ise_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// Latch the request, touch one stack entry, update the count.
	ise_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.req         (req),
		.stack_limit (stack_limit_q),
		.rsp         (rsp)
	);

endmodule

>>> hdl/ise_ctrl.sv
// Controller: sequences one request through load, execute and response.
module ise_ctrl
	import ise_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    done,
	output dp_ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl.load = 1'b0;
		ctl.exec = 1'b0;
		busy     = 1'b1;
		done     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/ise_dp.sv
// Datapath: request register, stack memory, entry count and response fields.
module ise_dp
	import ise_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_ctl_t            ctl,
	input  req_t               req,
	input  logic [LIMIT_W-1:0] stack_limit,
	output rsp_t               rsp
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	req_t                  req_q;
	logic [CNT_W-1:0]      count_q;
	logic [1:0]            status_q;
	logic                  rd_sel_q;
	logic [DATA_WIDTH-1:0] rd_word_q;

	logic signed [63:0]    val_ext;
	logic [DATA_WIDTH-1:0] wr_word;
	logic                  pos_ok;
	logic                  room;
	logic [CNT_W-1:0]      pos_cnt;
	logic [ADDR_W-1:0]     top_addr;
	logic [ADDR_W-1:0]     pos_addr;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ADDR_W-1:0]     wr_addr;
	logic                  wr_en;
	logic [CNT_W-1:0]      count_d;
	logic [1:0]            status_d;
	logic                  rd_sel_d;
	logic signed [DATA_WIDTH-1:0] rd_signed;
	logic signed [63:0]    rd_ext;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
	end

	assign val_ext  = 64'(req_q.value);
	assign wr_word  = val_ext[DATA_WIDTH-1:0];
	assign pos_cnt  = CNT_W'(req_q.position);
	// position must be 1..count; compare at full field width
	assign pos_ok   = (req_q.position != 5'd0) && (32'(req_q.position) <= 32'(count_q));
	assign room     = (32'(count_q) < 32'(stack_limit)) && (32'(count_q) < 32'(DEPTH));
	assign top_addr = ADDR_W'(count_q - CNT_W'(1));
	assign pos_addr = ADDR_W'(count_q - pos_cnt);

	always_comb begin
		count_d  = count_q;
		status_d = STS_OK;
		rd_sel_d = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = pos_addr;
		rd_addr  = pos_addr;
		case (cmd_t'(req_q.command))
			CMD_PUSH: begin
				wr_addr = ADDR_W'(count_q);
				if (room) begin
					wr_en   = 1'b1;
					count_d = count_q + CNT_W'(1);
				end else begin
					status_d = STS_OVERFLOW;
				end
			end
			CMD_POP: begin
				rd_addr = top_addr;
				if (count_q == '0) begin
					status_d = STS_UNDERFLOW;
				end else begin
					count_d  = count_q - CNT_W'(1);
					rd_sel_d = 1'b1;
				end
			end
			CMD_PEEK: begin
				if (pos_ok) begin
					rd_sel_d = 1'b1;
				end else begin
					status_d = STS_UNDERFLOW;
				end
			end
			CMD_CHANGE: begin
				if (pos_ok) begin
					wr_en = 1'b1;
				end else begin
					status_d = STS_UNDERFLOW;
				end
			end
			default: begin
				status_d = STS_UNDERFLOW;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && wr_en) begin
			mem[wr_addr] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= STS_OK;
			rd_sel_q <= 1'b0;
		end else if (ctl.exec) begin
			count_q  <= count_d;
			status_q <= status_d;
			rd_sel_q <= rd_sel_d;
		end
	end

	assign rd_signed = rd_word_q;
	assign rd_ext    = 64'(rd_signed);

	assign rsp.read_data = rd_sel_q ? rd_ext[31:0] : 32'sd0;
	assign rsp.status    = status_q;
	assign rsp.count_now = 5'(count_q);

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench: random and directed command stream for the indexed stack engine, checked by a tracker.
module testbench;
	import ise_pkg::*;

	localparam int WATCHDOG_CYCLES = 5000;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int NUM_PHASES      = 10;
	localparam int MAX_REPORTS     = 100;

	// Track the stack contents, the count and the limit, and hold the responses
	// that accepted requests will produce, oldest first.
	class stack_tracker;
		logic [DATA_WIDTH-1:0] words[DEPTH];
		int unsigned           entries;
		logic [LIMIT_W-1:0]    limit;
		rsp_t                  pending_rsp_q[$];
		int                    errors;

		function new();
			entries = 0;
			limit   = LIMIT_W'(16);
			errors  = 0;
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] lim);
			limit = lim;
		endfunction

		function int pending();
			return pending_rsp_q.size();
		endfunction

		function void note_error();
			errors++;
		endfunction

		// Apply one accepted request and queue the response it must give.
		function void note_request(req_t r);
			rsp_t                         e;
			int unsigned                  eff_limit;
			logic signed [DATA_WIDTH-1:0] w;
			eff_limit   = (limit < DEPTH) ? limit : DEPTH;
			e.read_data = '0;
			e.status    = STS_OK;
			case (cmd_t'(r.command))
				CMD_PUSH: begin
					if (entries < eff_limit) begin
						words[entries] = DATA_WIDTH'(r.value);
						entries++;
					end else begin
						e.status = STS_OVERFLOW;
					end
				end
				CMD_POP: begin
					if (entries == 0) begin
						e.status = STS_UNDERFLOW;
					end else begin
						entries--;
						w           = words[entries];
						e.read_data = 32'(w);
					end
				end
				CMD_PEEK: begin
					if (r.position == 0 || r.position > entries) begin
						e.status = STS_UNDERFLOW;
					end else begin
						w           = words[entries - r.position];
						e.read_data = 32'(w);
					end
				end
				default: begin
					if (r.position == 0 || r.position > entries) begin
						e.status = STS_UNDERFLOW;
					end else begin
						words[entries - r.position] = DATA_WIDTH'(r.value);
					end
				end
			endcase
			e.count_now = entries[4:0];
			pending_rsp_q.push_back(e);
		endfunction

		// Compare one response field by field with the oldest expectation.
		function void check_response(rsp_t a);
			rsp_t e;
			if (pending_rsp_q.size() == 0) begin
				errors++;
				$display("%0t: response with none expected: read_data %0d status %0d count %0d",
					$time, a.read_data, a.status, a.count_now);
				return;
			end
			e = pending_rsp_q.pop_front();
			if (a.read_data !== e.read_data) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: read_data expected %0d actual %0d",
						$time, e.read_data, a.read_data);
			end
			if (a.status !== e.status) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
			end
			if (a.count_now !== e.count_now) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: count_now expected %0d actual %0d",
						$time, e.count_now, a.count_now);
			end
		endfunction
	endclass

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic               busy;
	req_t               req     = '0;
	logic               done;
	rsp_t               rsp;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [31:0]        pwdata  = '0;
	logic [31:0]        prdata;
	logic               pready;

	stack_tracker tracker = new();
	int           quiet_cycles = 0;
	int           idle_pct = 0;

	indexed_stack_engine i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Monitor: sample both handshakes at the edge that accepts them, and drop
	// the run if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_response(rsp);
			if (start && !busy)
				tracker.note_request(req);
			if (done || (start && !busy)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= WATCHDOG_CYCLES) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	// Present one request and hold it until accepted; then drop start for the
	// gap, and when asked hold off until every response has come back.
	task automatic issue(input req_t r, input int gap, input bit hold);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		if (gap > 0 || hold) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			if (hold)
				wait_drained();
		end
	endtask

	// Hold until the tracker expects nothing and the block is idle.
	task automatic wait_drained();
		while (tracker.pending() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the limit register over APB, then read it back.
	task automatic write_limit(input logic [LIMIT_W-1:0] lim);
		logic [31:0] wd;
		wd          = $urandom();
		wd[4:0]     = lim;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(REG_STACK_LIMIT));
		pwdata  <= wd;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_limit(lim);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[LIMIT_W-1:0] !== lim) begin
			tracker.note_error();
			$display("%0t: stack_limit read back expected %0d actual %0d",
				$time, lim, prdata[LIMIT_W-1:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic req_t make_cmd(cmd_t c, logic signed [31:0] v, logic [4:0] p);
		req_t r;
		r.command  = c;
		r.value    = v;
		r.position = p;
		return r;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return 32'sh7FFFFFFF;
			1:       return 32'sh80000000;
			2:       return -32'sd1;
			3:       return 32'sd0;
			default: return $urandom();
		endcase
	endfunction

	// Build a mostly well-formed request: positions inside the stack, a push
	// bias that lets the stack fill up to the limit, and some noise.
	function automatic req_t make_random();
		req_t        r;
		int unsigned roll;
		int unsigned cnt;
		cnt  = tracker.entries;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			r.command = CMD_PUSH;
		else if (roll < 62)
			r.command = CMD_POP;
		else if (roll < 82)
			r.command = CMD_PEEK;
		else
			r.command = CMD_CHANGE;
		r.value = pick_value();
		if (cnt > 0 && $urandom_range(0, 99) < 85)
			r.position = 5'($urandom_range(1, cnt));
		else
			r.position = 5'($urandom_range(0, 31));
		return r;
	endfunction

	function automatic logic [LIMIT_W-1:0] phase_limit(int ph);
		case (ph)
			0:       return 5'd16;
			1:       return 5'd1;
			2:       return 5'd31;
			3:       return 5'd0;
			4:       return 5'd8;
			5:       return 5'd16;
			6:       return 5'($urandom_range(0, 16));
			7:       return 5'd2;
			8:       return 5'd31;
			default: return 5'd16;
		endcase
	endfunction

	initial begin
		int gap;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at the reset limit: empty-stack errors first, then
		// extreme words, positions at and past the count, and a change.
		issue(make_cmd(CMD_POP, 32'sd0, 5'd0), 0, 1'b0);
		issue(make_cmd(CMD_PEEK, 32'sd0, 5'd1), 0, 1'b0);
		issue(make_cmd(CMD_CHANGE, 32'sd7, 5'd1), 0, 1'b0);
		issue(make_cmd(CMD_PUSH, 32'sh7FFFFFFF, 5'd0), 0, 1'b0);
		issue(make_cmd(CMD_PUSH, 32'sh80000000, 5'd31), 0, 1'b0);
		issue(make_cmd(CMD_PUSH, -32'sd1, 5'd0), 0, 1'b0);
		issue(make_cmd(CMD_PUSH, 32'sd0, 5'd16), 0, 1'b0);
		issue(make_cmd(CMD_PEEK, 32'sd0, 5'd1), 0, 1'b0);
		issue(make_cmd(CMD_PEEK, 32'sd0, 5'd4), 0, 1'b0);
		issue(make_cmd(CMD_PEEK, 32'sd0, 5'd5), 0, 1'b0);
		issue(make_cmd(CMD_PEEK, 32'sd0, 5'd0), 0, 1'b0);
		issue(make_cmd(CMD_PEEK, 32'sd0, 5'd31), 0, 1'b0);
		issue(make_cmd(CMD_CHANGE, 32'sh5A5A5A5A, 5'd2), 0, 1'b0);
		issue(make_cmd(CMD_PEEK, 32'sd0, 5'd2), 0, 1'b0);
		issue(make_cmd(CMD_CHANGE, 32'sd3, 5'd0), 0, 1'b0);
		issue(make_cmd(CMD_CHANGE, 32'sd3, 5'd16), 0, 1'b0);
		repeat (4) issue(make_cmd(CMD_POP, 32'sd0, 5'd0), 0, 1'b0);
		issue(make_cmd(CMD_POP, 32'sd0, 5'd0), 0, 1'b0);
		start <= 1'b0;
		wait_drained();

		// Small limit: fill, then push into a full stack.
		write_limit(5'd2);
		issue(make_cmd(CMD_PUSH, 32'sd11, 5'd0), 0, 1'b0);
		issue(make_cmd(CMD_PUSH, 32'sd22, 5'd0), 0, 1'b0);
		issue(make_cmd(CMD_PUSH, 32'sd33, 5'd0), 0, 1'b0);
		issue(make_cmd(CMD_POP, 32'sd0, 5'd0), 0, 1'b0);
		start <= 1'b0;
		wait_drained();

		// Random phases: a new limit each time, with the sender idle never,
		// often or rarely by turns.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_limit(phase_limit(ph));
			case (ph % 3)
				0:       idle_pct = 0;
				1:       idle_pct = 59;
				default: idle_pct = 10;
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
				issue(make_random(), gap, ($urandom_range(0, 99) < 2));
			end
			start <= 1'b0;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
